// ===== hw/rtl/fbb_pkg.sv =====
// Shared types and constants of the framebuffer pixel blend block.
// No dependencies; every other file of the block imports this package.
package fbb_pkg;

	localparam int RGB_W     = 24;
	localparam int CHAN_W    = 8;
	localparam int ALPHA_W   = 8;
	localparam int PIXEL_W   = 32;
	localparam int OFFS_W    = 34;
	localparam int DIM_W     = 16;
	localparam int PITCH_W   = 18;
	localparam int BPP_W     = 3;
	localparam int LAYOUT_W  = 9;
	localparam int SIZE_W    = 4;
	localparam int SHIFT_W   = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 18;

	localparam logic [BPP_W-1:0]  BPP_MAX    = 3'd4;
	localparam logic [SIZE_W-1:0] CHAN_SZ_MAX = 4'd8;

	typedef logic [RGB_W-1:0]    rgb_t;
	typedef logic [CHAN_W-1:0]   chan_t;
	typedef logic [PIXEL_W-1:0]  pixel_t;
	typedef logic [LAYOUT_W-1:0] layout_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLED     = 3'd0,
		REG_WIDTH       = 3'd1,
		REG_HEIGHT      = 3'd2,
		REG_PITCH       = 3'd3,
		REG_BPP         = 3'd4,
		REG_RED_LAYOUT  = 3'd5,
		REG_GRN_LAYOUT  = 3'd6,
		REG_BLU_LAYOUT  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic               enabled;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [PITCH_W-1:0] pitch;
		logic [BPP_W-1:0]   bpp;      // already saturated to 4
		layout_t            red;
		layout_t            green;
		layout_t            blue;
	} fbb_cfg_t;

	// field size saturated to 8
	function automatic logic [SIZE_W-1:0] chan_size(input layout_t lay);
		logic [SIZE_W-1:0] s;
		s = lay[SIZE_W-1:0];
		return (s > CHAN_SZ_MAX) ? CHAN_SZ_MAX : s;
	endfunction

	function automatic logic [SHIFT_W-1:0] chan_shift(input layout_t lay);
		return lay[LAYOUT_W-1:SIZE_W];
	endfunction

endpackage

// ===== hw/rtl/fbb_if.sv =====
// Valid/ready channel interfaces for pixel items and blend results.
// Depends on fbb_pkg for payload widths.
interface fbb_in_if
	import fbb_pkg::*;
#(
	parameter int COORD_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;
	logic [RGB_W-1:0]      src_color;
	logic [ALPHA_W-1:0]    src_alpha;
	logic [PIXEL_W-1:0]    dest_pixel;

	modport source (output valid, pos_x, pos_y, src_color, src_alpha, dest_pixel,
		input ready);
	modport sink (input valid, pos_x, pos_y, src_color, src_alpha, dest_pixel,
		output ready);
endinterface

interface fbb_out_if
	import fbb_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               write_enable;
	logic [OFFS_W-1:0]  byte_offset;
	logic [PIXEL_W-1:0] pixel_value;

	modport source (output valid, write_enable, byte_offset, pixel_value, input ready);
	modport sink (input valid, write_enable, byte_offset, pixel_value, output ready);
endinterface

// ===== hw/rtl/fbb_cfg_regs.sv =====
// Configuration register file of the pixel blend block.
// Depends on fbb_pkg for the register index codes and the config struct.
module fbb_cfg_regs
	import fbb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output fbb_cfg_t             cfg
);
	logic               enabled_q;
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [PITCH_W-1:0] pitch_q;
	logic [BPP_W-1:0]   bpp_q;
	layout_t            red_q;
	layout_t            green_q;
	layout_t            blue_q;
	cfg_idx_t           idx;

	assign idx = cfg_idx_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			width_q   <= '0;
			height_q  <= '0;
			pitch_q   <= '0;
			bpp_q     <= BPP_MAX;
			red_q     <= '0;
			green_q   <= '0;
			blue_q    <= '0;
		end else if (cfg_write) begin
			unique case (idx)
				REG_ENABLED:    enabled_q <= cfg_data[0];
				REG_WIDTH:      width_q   <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:     height_q  <= cfg_data[DIM_W-1:0];
				REG_PITCH:      pitch_q   <= cfg_data[PITCH_W-1:0];
				REG_BPP:        bpp_q     <= cfg_data[BPP_W-1:0];
				REG_RED_LAYOUT: red_q     <= cfg_data[LAYOUT_W-1:0];
				REG_GRN_LAYOUT: green_q   <= cfg_data[LAYOUT_W-1:0];
				REG_BLU_LAYOUT: blue_q    <= cfg_data[LAYOUT_W-1:0];
			endcase
		end
	end

	always_comb begin
		cfg.enabled = enabled_q;
		cfg.width   = width_q;
		cfg.height  = height_q;
		cfg.pitch   = pitch_q;
		cfg.bpp     = (bpp_q > BPP_MAX) ? BPP_MAX : bpp_q;
		cfg.red     = red_q;
		cfg.green   = green_q;
		cfg.blue    = blue_q;
	end

endmodule

// ===== hw/rtl/fbb_unpack.sv =====
// Unpacks a raw stored pixel into 8-bit red, green and blue channels.
// Depends on fbb_pkg for the config struct and layout helpers.
module fbb_unpack
	import fbb_pkg::*;
(
	input  fbb_cfg_t cfg,
	input  pixel_t   raw,
	output rgb_t     rgb
);
	pixel_t  raw_m;
	layout_t lay [3];

	assign lay[0] = cfg.red;
	assign lay[1] = cfg.green;
	assign lay[2] = cfg.blue;

	// drop bytes above bytes_per_pixel
	always_comb begin
		unique case (cfg.bpp)
			3'd0:    raw_m = '0;
			3'd1:    raw_m = raw & 32'h0000_00FF;
			3'd2:    raw_m = raw & 32'h0000_FFFF;
			3'd3:    raw_m = raw & 32'h00FF_FFFF;
			default: raw_m = raw;
		endcase
	end

	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [SIZE_W-1:0] sz;
		logic [SIZE_W-1:0] pad;
		pixel_t            shifted;
		chan_t             field;
		chan_t             mask;

		always_comb begin
			sz      = chan_size(lay[c]);
			pad     = CHAN_SZ_MAX - sz;
			shifted = raw_m >> chan_shift(lay[c]);
			mask    = 8'hFF >> pad;
			field   = shifted[CHAN_W-1:0] & mask;
		end

		// widen the field by a left shift to a full 8-bit channel
		assign rgb[RGB_W-1-CHAN_W*c -: CHAN_W] = field << pad;
	end

endmodule

// ===== hw/rtl/fbb_pack.sv =====
// Packs 8-bit red, green and blue channels into a raw pixel word.
// Depends on fbb_pkg for the config struct and layout helpers.
module fbb_pack
	import fbb_pkg::*;
(
	input  fbb_cfg_t cfg,
	input  rgb_t     rgb,
	output pixel_t   raw
);
	layout_t lay [3];
	pixel_t  part [3];

	assign lay[0] = cfg.red;
	assign lay[1] = cfg.green;
	assign lay[2] = cfg.blue;

	for (genvar c = 0; c < 3; c++) begin : g_chan
		chan_t v;

		// keep the top bits of the channel; bits past bit 31 fall off
		always_comb begin
			v       = rgb[RGB_W-1-CHAN_W*c -: CHAN_W] >> (CHAN_SZ_MAX - chan_size(lay[c]));
			part[c] = PIXEL_W'(v) << chan_shift(lay[c]);
		end
	end

	assign raw = part[0] | part[1] | part[2];

endmodule

// ===== hw/rtl/framebuffer_pixel_blend.sv =====
// Top level of the framebuffer pixel blend: four-stage blend pipeline.
// Depends on fbb_pkg, fbb_if, fbb_cfg_regs, fbb_unpack and fbb_pack.
//
//  Port     Kind          Direction  Payload
//  cfg_*    write port    in         cfg_index, cfg_data (cfg_write strobe)
//  pix_in   valid/ready   in         pos_x, pos_y, src_color, src_alpha, dest_pixel
//  pix_out  valid/ready   out        write_enable, byte_offset, pixel_value
//
// One item per cycle sustained while pix_out is not stalled; each item passes
// four pipeline register stages (bounds/unpack/row multiply, blend multiply,
// divide by 255, pack), the last of which is the pix_out output register.
// Reset clears all valid bits and resets the configuration registers (bpp to
// 4, the rest to zero); payload registers are not reset. A stall on pix_out
// holds only the stages that are full, so bubbles close up and pix_in keeps
// accepting until every stage holds an item.
module framebuffer_pixel_blend
	import fbb_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	fbb_in_if.sink               pix_in,
	fbb_out_if.source            pix_out
);
	// compare width for coordinates against 16-bit screen limits
	localparam int CMP_W  = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;
	// wide enough for y*pitch + x*bpp before cutting to the offset width
	localparam int WIDE_W = (COORD_BITS + PITCH_W + 1 > OFFS_W) ?
		COORD_BITS + PITCH_W + 1 : OFFS_W;
	localparam int XB_W   = COORD_BITS + BPP_W;
	localparam int SUM_W  = 2 * CHAN_W;

	fbb_cfg_t cfg;
	rgb_t     dst_rgb;
	logic     in_take;
	logic     in_write;
	logic     rdy1, rdy2, rdy3, rdy4;
	logic     valid_s1;
	logic     valid_s2;
	logic     valid_s3;

	fbb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Unpack the stored pixel straight off the input; it runs beside the
	// row multiply so stage 1 stays about one multiplier deep.
	fbb_unpack u_unpack (
		.cfg (cfg),
		.raw (pix_in.dest_pixel),
		.rgb (dst_rgb)
	);

	// Ready ripples back from the output: a stage takes a new item when it
	// is empty or the stage after it moves on this cycle.
	assign rdy4         = !pix_out.valid || pix_out.ready;
	assign rdy3         = !valid_s3 || rdy4;
	assign rdy2         = !valid_s2 || rdy3;
	assign rdy1         = !valid_s1 || rdy2;
	assign pix_in.ready = rdy1;
	assign in_take      = pix_in.valid && rdy1;

	// Write only when enabled, in bounds and not fully transparent.
	assign in_write = cfg.enabled
		&& (CMP_W'(pix_in.pos_x) < CMP_W'(cfg.width))
		&& (CMP_W'(pix_in.pos_y) < CMP_W'(cfg.height))
		&& (pix_in.src_alpha != '0);

	// ---------------- stage 1: bounds, row multiply, unpack ----------------
	logic              we_s1;
	logic [WIDE_W-1:0] row_s1;
	logic [XB_W-1:0]   xb_s1;
	rgb_t              src_s1;
	rgb_t              dst_s1;
	chan_t             alpha_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy1) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			we_s1    <= in_write;
			row_s1   <= WIDE_W'(pix_in.pos_y) * WIDE_W'(cfg.pitch);
			xb_s1    <= XB_W'(pix_in.pos_x) * XB_W'(cfg.bpp);
			src_s1   <= pix_in.src_color;
			dst_s1   <= dst_rgb;
			alpha_s1 <= pix_in.src_alpha;
		end
	end

	// ---------------- stage 2: channel products, offset sum ----------------
	// Alpha 255 needs no bypass: s*255 + d*0 divided by 255 is s exactly.
	logic              we_s2;
	logic [OFFS_W-1:0] offs_s2;
	logic [SUM_W-1:0]  sum_s2 [3];
	logic [WIDE_W-1:0] offs_wide;
	chan_t             inv_alpha;

	assign offs_wide = row_s1 + WIDE_W'(xb_s1);
	assign inv_alpha = 8'hFF - alpha_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			we_s2   <= we_s1;
			offs_s2 <= offs_wide[OFFS_W-1:0];
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_mix
		chan_t s;
		chan_t d;

		assign s = src_s1[RGB_W-1-CHAN_W*c -: CHAN_W];
		assign d = dst_s1[RGB_W-1-CHAN_W*c -: CHAN_W];

		always_ff @(posedge clk) begin
			if (rdy2 && valid_s1) begin
				sum_s2[c] <= SUM_W'(s) * SUM_W'(alpha_s1) + SUM_W'(d) * SUM_W'(inv_alpha);
			end
		end
	end

	// ---------------- stage 3: floor divide by 255 ----------------
	// For n up to 65534, floor(n/255) = (n + 1 + (n >> 8)) >> 8.
	logic              we_s3;
	logic [OFFS_W-1:0] offs_s3;
	rgb_t              mix_s3;
	rgb_t              mix_d;

	for (genvar c = 0; c < 3; c++) begin : g_div
		logic [SUM_W:0] t;

		assign t = (SUM_W+1)'(sum_s2[c]) + (SUM_W+1)'(1) + (SUM_W+1)'(sum_s2[c] >> CHAN_W);
		assign mix_d[RGB_W-1-CHAN_W*c -: CHAN_W] = t[2*CHAN_W-1:CHAN_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			we_s3   <= we_s2;
			offs_s3 <= offs_s2;
			mix_s3  <= mix_d;
		end
	end

	// ---------------- stage 4: pack and output register ----------------
	pixel_t packed_px;

	fbb_pack u_pack (
		.cfg (cfg),
		.rgb (mix_s3),
		.raw (packed_px)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_out.valid <= 1'b0;
		end else if (rdy4) begin
			pix_out.valid <= valid_s3;
		end
	end

	// Zero the whole result when the pixel is not written.
	always_ff @(posedge clk) begin
		if (rdy4 && valid_s3) begin
			pix_out.write_enable <= we_s3;
			pix_out.byte_offset  <= we_s3 ? offs_s3 : '0;
			pix_out.pixel_value  <= we_s3 ? packed_px : '0;
		end
	end

endmodule
